[hw/rtl/utf8s_pkg.sv]
// Shared types, constants and the lead byte classifier for the UTF-8 stream sanitizer.
package utf8s_pkg;

   localparam int unsigned HeldDepth  = 3;
   localparam int unsigned MaxResults = 4;

   localparam logic [7:0] QMARK = 8'd63;

   // Result of classifying a byte that starts a new sequence.
   localparam logic [2:0] LEN_INVALID = 3'd0;
   localparam logic [2:0] LEN_SINGLE  = 3'd1;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       was_replaced;
      logic       run_last;
      logic       message_last;
   } result_type;

   typedef result_type [MaxResults-1:0] result_list_type;

   typedef struct packed {
      logic [HeldDepth-1:0][7:0] held_bytes;
      logic [1:0]                held_count;
      logic [2:0]                sequence_length;
   } seq_state_type;

   // Expected sequence length of a starting byte; LEN_INVALID for NUL,
   // stray continuation bytes and leads that can never be well formed.
   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      if (b == 8'h00) begin
         len = LEN_INVALID;
      end else if (b < 8'h80) begin
         len = LEN_SINGLE;
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
         len = 3'd2;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
         len = 3'd3;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
         len = 3'd4;
      end else begin
         len = LEN_INVALID;
      end
      return len;
   endfunction

endpackage

[hw/rtl/utf8s_req_if.sv]
// Input byte channel: valid/ready handshake carrying one raw byte and its message end flag.
interface utf8s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       message_end;

   modport source (output valid, output data_byte, output message_end, input ready);
   modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

[hw/rtl/utf8s_rsp_if.sv]
// Result byte channel: valid/ready handshake carrying one emitted byte and its flags.
interface utf8s_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       was_replaced;
   logic       run_last;
   logic       message_last;

   modport source (output valid, output out_byte, output was_replaced, output run_last,
                   output message_last, input ready);
   modport sink   (input valid, input out_byte, input was_replaced, input run_last,
                   input message_last, output ready);
endinterface

[hw/rtl/utf8s_decode.sv]
// Combinational UTF-8 step: from the pending sequence and one byte, the result list and next state.
module utf8s_decode (
   input  utf8s_pkg::seq_state_type   cur_state,
   input  logic [7:0]                 data_byte,
   input  logic                       message_end,
   output utf8s_pkg::result_list_type results,
   output logic [2:0]                 result_count,
   output utf8s_pkg::seq_state_type   nxt_state
);

   logic [2:0] k;
   logic [1:0] last_idx;
   logic [7:0] lo;
   logic [7:0] hi;
   logic       start_b;
   logic [2:0] cls;

   always_comb begin
      results   = '0;
      nxt_state = cur_state;
      k         = '0;
      start_b   = 1'b0;
      lo        = 8'h80;
      hi        = 8'hBF;
      cls       = utf8s_pkg::lead_len(data_byte);

      if (cur_state.held_count == 2'd0) begin
         start_b = 1'b1;
      end else begin
         // The second byte of a few leads has a narrower legal range.
         if (cur_state.held_count == 2'd1) begin
            case (cur_state.held_bytes[0])
               8'hE0:   lo = 8'hA0;
               8'hED:   hi = 8'h9F;
               8'hF0:   lo = 8'h90;
               8'hF4:   hi = 8'h8F;
               default: ;
            endcase
         end
         if (data_byte >= lo && data_byte <= hi) begin
            if ({1'b0, cur_state.held_count} + 3'd1 >= cur_state.sequence_length) begin
               for (int i = 0; i < utf8s_pkg::HeldDepth; i++) begin
                  if (2'(i) < cur_state.held_count) begin
                     results[k[1:0]].out_byte = cur_state.held_bytes[i];
                     k = k + 3'd1;
                  end
               end
               results[k[1:0]].out_byte = data_byte;
               k = k + 3'd1;
               nxt_state.held_count      = '0;
               nxt_state.sequence_length = '0;
            end else begin
               nxt_state.held_bytes[cur_state.held_count] = data_byte;
               nxt_state.held_count = cur_state.held_count + 2'd1;
            end
         end else begin
            // Bad continuation: every held byte turns into a replacement.
            for (int i = 0; i < utf8s_pkg::HeldDepth; i++) begin
               if (2'(i) < cur_state.held_count) begin
                  results[k[1:0]].out_byte     = utf8s_pkg::QMARK;
                  results[k[1:0]].was_replaced = 1'b1;
                  k = k + 3'd1;
               end
            end
            nxt_state.held_count      = '0;
            nxt_state.sequence_length = '0;
            start_b = 1'b1;
         end
      end

      if (start_b) begin
         if (cls == utf8s_pkg::LEN_INVALID) begin
            results[k[1:0]].out_byte     = utf8s_pkg::QMARK;
            results[k[1:0]].was_replaced = 1'b1;
            k = k + 3'd1;
         end else if (cls == utf8s_pkg::LEN_SINGLE) begin
            results[k[1:0]].out_byte = data_byte;
            k = k + 3'd1;
         end else begin
            nxt_state.held_bytes[0]   = data_byte;
            nxt_state.held_count      = 2'd1;
            nxt_state.sequence_length = cls;
         end
      end

      // A sequence still open at message end is flushed as replacements.
      if (message_end && nxt_state.held_count != 2'd0) begin
         for (int i = 0; i < utf8s_pkg::HeldDepth; i++) begin
            if (2'(i) < nxt_state.held_count) begin
               results[k[1:0]].out_byte     = utf8s_pkg::QMARK;
               results[k[1:0]].was_replaced = 1'b1;
               k = k + 3'd1;
            end
         end
         nxt_state.held_count      = '0;
         nxt_state.sequence_length = '0;
      end

      last_idx = 2'(k - 3'd1);
      if (k != 3'd0) begin
         results[last_idx].run_last     = 1'b1;
         results[last_idx].message_last = message_end;
      end
      result_count = k;
   end

endmodule

[hw/rtl/utf8s_rsp_buf.sv]
// Result buffer: holds one byte's results and sends one per cycle while rsp is ready.
module utf8s_rsp_buf (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load_valid,
   input  utf8s_pkg::result_list_type load_results,
   input  logic [2:0]                 load_count,
   output logic                       can_load,
   utf8s_rsp_if.source                rsp
);

   utf8s_pkg::result_list_type entries_ff;
   logic [2:0]                 rem_ff;
   logic [2:0]                 rem_in;
   logic [1:0]                 rd_ff;
   logic [1:0]                 rd_in;
   logic                       xfer;
   logic                       load;

   assign xfer     = rsp.valid && rsp.ready;
   assign can_load = (rem_ff == 3'd0) || (rem_ff == 3'd1 && rsp.ready);
   assign load     = load_valid && can_load;

   always_comb begin
      rem_in = rem_ff;
      rd_in  = rd_ff;
      if (load) begin
         rem_in = load_count;
         rd_in  = '0;
      end else if (xfer) begin
         rem_in = rem_ff - 3'd1;
         rd_in  = rd_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         rd_ff  <= '0;
      end else begin
         rem_ff <= rem_in;
         rd_ff  <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entries_ff <= load_results;
      end
   end

   assign rsp.valid        = (rem_ff != 3'd0);
   assign rsp.out_byte     = entries_ff[rd_ff].out_byte;
   assign rsp.was_replaced = entries_ff[rd_ff].was_replaced;
   assign rsp.run_last     = entries_ff[rd_ff].run_last;
   assign rsp.message_last = entries_ff[rd_ff].message_last;

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load |=> rem_ff == $past(load_count))
      else $error("result count not taken on load");

   a_run_last_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.run_last == (rem_ff == 3'd1)))
      else $error("run_last does not match the last buffered result");

   a_msg_last_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.message_last) |-> rsp.run_last)
      else $error("message_last on a result that is not the last of its byte");

endmodule

[hw/rtl/utf8_stream_sanitizer_top.sv]
// Top level of the UTF-8 stream sanitizer: input register, sequence state and result buffer.
// A byte accepted into the input register passes to the result register before its first
// result shows on rsp (one input register, one result register).
// Throughput: one byte per cycle while rsp is ready and each byte gives at most one result;
// a byte with k results (up to four) holds the port until the one-wide output has sent all k.
// Reset (synchronous, active high) empties the input register and the result buffer and
// drops any pending multi-byte sequence; the held byte store itself is not cleared.
module utf8_stream_sanitizer_top (
   input  logic        clock,
   input  logic        reset,
   utf8s_req_if.sink   req,
   utf8s_rsp_if.source rsp
);

   // Input register. It takes a new byte whenever it is empty or its byte moves on,
   // so a byte can be accepted while a finished result still waits on rsp.
   logic       req_valid_ff;
   logic       req_valid_in;
   logic [7:0] req_byte_ff;
   logic       req_end_ff;
   logic       req_xfer;

   // Pending sequence state. The held bytes carry no reset: an entry is only read
   // after it was written, guarded by the count.
   utf8s_pkg::seq_state_type seq_ff;
   utf8s_pkg::seq_state_type seq_in;

   utf8s_pkg::result_list_type dec_results;
   logic [2:0]                 dec_count;
   logic                       can_load;
   logic                       advance;

   // A byte leaves the input register when the result buffer can take its results.
   // Bytes that only extend a sequence give no results and pass just the same.
   assign advance   = req_valid_ff && can_load;
   assign req.ready = !req_valid_ff || advance;
   assign req_xfer  = req.valid && req.ready;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_xfer) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_byte_ff <= req.data_byte;
         req_end_ff  <= req.message_end;
      end
   end

   // All of the per-byte work is one pass of combinational logic.
   utf8s_decode u_decode (
      .cur_state    (seq_ff),
      .data_byte    (req_byte_ff),
      .message_end  (req_end_ff),
      .results      (dec_results),
      .result_count (dec_count),
      .nxt_state    (seq_in)
   );

   // Sequence state moves only when the byte in the input register is consumed.
   // Reset clears the count and length; the held bytes keep whatever they had.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff.held_count      <= '0;
         seq_ff.sequence_length <= '0;
      end else if (advance) begin
         seq_ff <= seq_in;
      end
   end

   utf8s_rsp_buf u_rsp_buf (
      .clock        (clock),
      .reset        (reset),
      .load_valid   (advance),
      .load_results (dec_results),
      .load_count   (dec_count),
      .can_load     (can_load),
      .rsp          (rsp)
   );

   a_len_covers_count: assert property (@(posedge clock) disable iff (reset)
      seq_ff.held_count != 2'd0 |-> seq_ff.sequence_length > {1'b0, seq_ff.held_count})
      else $error("held count reached the expected sequence length");

   a_idle_len_zero: assert property (@(posedge clock) disable iff (reset)
      seq_ff.held_count == 2'd0 |-> seq_ff.sequence_length == 3'd0)
      else $error("sequence length set with nothing held");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && req_end_ff) |=> seq_ff.held_count == 2'd0)
      else $error("sequence still pending after message end");

   a_end_has_result: assert property (@(posedge clock) disable iff (reset)
      (advance && req_end_ff) |-> dec_count != 3'd0)
      else $error("message end byte produced no result");

endmodule

[verif/tb_utf8_stream_sanitizer_top.sv]
// Self-checking testbench for the UTF-8 stream sanitizer: byte-level prediction and result checks.
`timescale 1ns / 100ps

module tb_utf8_stream_sanitizer_top;

   // The random part stops after this many accepted input bytes.
   localparam int unsigned RandomBytes = 406;
   // Cycles allowed for the result queue to empty once the last byte is accepted.
   localparam int unsigned DrainLimit  = 2000;

   logic clock;
   logic reset;

   utf8s_req_if req_bus ();
   utf8s_rsp_if rsp_bus ();

   utf8_stream_sanitizer_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // 20 ns period, starting low so that the first rising edge is a clean one.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ---------------------------------------------------------------------------------------------
   // Predictor state. It mirrors the pending multi-byte sequence of the block: the bytes held so
   // far, how many there are, and how long the sequence promised to be from its lead byte.
   // ---------------------------------------------------------------------------------------------
   logic [7:0] pending_bytes [0:utf8s_pkg::HeldDepth-1];
   logic [1:0] pending_count;
   logic [2:0] promised_len;

   // Results of the byte currently being predicted, before the end flags are attached.
   utf8s_pkg::result_type byte_results [$];
   // Every result that the block still owes us, oldest first.
   utf8s_pkg::result_type sanitized_q [$];

   // Bytes of one character (or a broken fragment of one) waiting to be sent.
   logic [7:0] char_bytes [$];

   // Idle controls for the two sides; the random test moves them between phases.
   bit stall_send;
   bit stall_recv;
   int unsigned recv_gap;

   // Bookkeeping for the summary and the verdict.
   int unsigned mismatches;
   int unsigned bytes_sent;
   int unsigned messages_sent;
   int unsigned results_checked;
   int unsigned replacements_seen;

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   // Sequence length promised by a byte that starts a new sequence. NUL, continuation bytes and
   // leads that can only begin an overlong or out-of-range code point promise nothing.
   function automatic logic [2:0] promised_length(input logic [7:0] b);
      logic [2:0] len;
      if (b[7] == 1'b0) begin
         len = (b == 8'h00) ? utf8s_pkg::LEN_INVALID : utf8s_pkg::LEN_SINGLE;
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
         len = 3'd2;
      end else if (b[7:4] == 4'hE) begin
         len = 3'd3;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
         len = 3'd4;
      end else begin
         len = utf8s_pkg::LEN_INVALID;
      end
      return len;
   endfunction

   function automatic void emit_byte(input logic [7:0] b, input logic replaced);
      utf8s_pkg::result_type r;
      r.out_byte     = b;
      r.was_replaced = replaced;
      r.run_last     = 1'b0;
      r.message_last = 1'b0;
      byte_results = {byte_results, r};
   endfunction

   // A failed sequence turns every byte held so far into a question mark.
   function automatic void discard_pending();
      for (int i = 0; i < int'(pending_count); i++) begin
         emit_byte(utf8s_pkg::QMARK, 1'b1);
      end
      pending_count = '0;
      promised_len  = '0;
   endfunction

   // Examines a byte as the first byte of a new sequence.
   function automatic void start_sequence(input logic [7:0] b);
      logic [2:0] len;
      len = promised_length(b);
      if (len == utf8s_pkg::LEN_INVALID) begin
         emit_byte(utf8s_pkg::QMARK, 1'b1);
      end else if (len == utf8s_pkg::LEN_SINGLE) begin
         emit_byte(b, 1'b0);
      end else begin
         pending_bytes[0] = b;
         pending_count    = 2'd1;
         promised_len     = len;
      end
   endfunction

   // Predicts the results of one accepted input byte and queues them for the checker.
   function automatic void sanitize_byte(input logic [7:0] b, input logic eom);
      logic [7:0] lo;
      logic [7:0] hi;
      byte_results.delete();
      if (pending_count == 2'd0) begin
         start_sequence(b);
      end else begin
         // The second byte of some leads has a narrower range: this is what rules out
         // overlongs, surrogates and code points above 10FFFF.
         lo = 8'h80;
         hi = 8'hBF;
         if (pending_count == 2'd1) begin
            case (pending_bytes[0])
               8'hE0: lo = 8'hA0;
               8'hED: hi = 8'h9F;
               8'hF0: lo = 8'h90;
               8'hF4: hi = 8'h8F;
               default: ;
            endcase
         end
         if (b >= lo && b <= hi) begin
            if (int'(pending_count) + 1 >= int'(promised_len)) begin
               for (int i = 0; i < int'(pending_count); i++) begin
                  emit_byte(pending_bytes[i], 1'b0);
               end
               emit_byte(b, 1'b0);
               pending_count = '0;
               promised_len  = '0;
            end else begin
               pending_bytes[pending_count] = b;
               pending_count++;
            end
         end else begin
            // The byte that broke the sequence gets a second look as a fresh start.
            discard_pending();
            start_sequence(b);
         end
      end
      if (eom && pending_count != 2'd0) begin
         discard_pending();
      end
      if (byte_results.size() > 0) begin
         byte_results[byte_results.size() - 1].run_last     = 1'b1;
         byte_results[byte_results.size() - 1].message_last = eom;
      end
      foreach (byte_results[i]) begin
         sanitized_q = {sanitized_q, byte_results[i]};
      end
   endfunction

   // ---------------------------------------------------------------------------------------------
   // Input side. Each call starts at a falling edge, optionally idles for a burst, offers the byte
   // and returns at the falling edge after the transfer. Valid is left high on return so that
   // back-to-back bytes never see it lowered and raised in the same time step.
   // ---------------------------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b, input logic eom);
      int unsigned gap;
      if (stall_send && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 17);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= b;
      req_bus.message_end <= eom;
      do begin
         @(posedge clock);
      end while (req_bus.ready !== 1'b1);
      // The transfer happened at this edge, so the predictor sees the byte now.
      sanitize_byte(b, eom);
      bytes_sent++;
      if (eom) begin
         messages_sent++;
      end
      @(negedge clock);
   endtask

   // Sends the bytes of char_bytes, with the message end flag on the last one if asked.
   task automatic send_char(input logic eom);
      for (int i = 0; i < char_bytes.size(); i++) begin
         push_byte(char_bytes[i], eom && (i == char_bytes.size() - 1));
      end
   endtask

   // Builds a well-formed character of the given length with random content. The second byte
   // obeys the narrowed range of E0, ED, F0 and F4.
   function automatic void make_char(input int unsigned len);
      logic [7:0] lead;
      logic [7:0] lo;
      logic [7:0] hi;
      char_bytes.delete();
      case (len)
         2:       lead = 8'($urandom_range(8'hC2, 8'hDF));
         3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
         default: lead = 8'($urandom_range(8'hF0, 8'hF4));
      endcase
      char_bytes = {char_bytes, lead};
      lo = 8'h80;
      hi = 8'hBF;
      if (lead == 8'hE0) lo = 8'hA0;
      if (lead == 8'hED) hi = 8'h9F;
      if (lead == 8'hF0) lo = 8'h90;
      if (lead == 8'hF4) hi = 8'h8F;
      char_bytes = {char_bytes, 8'($urandom_range(lo, hi))};
      for (int i = 2; i < int'(len); i++) begin
         char_bytes = {char_bytes, 8'($urandom_range(8'h80, 8'hBF))};
      end
   endfunction

   // ---------------------------------------------------------------------------------------------
   // Result side. Ready changes at the falling edge; it drops for random bursts while receiver
   // stalls are enabled and otherwise stays high.
   // ---------------------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (recv_gap > 0) begin
         recv_gap--;
      end else if (stall_recv && $urandom_range(0, 4) == 0) begin
         rsp_bus.ready <= 1'b0;
         recv_gap = $urandom_range(0, 16);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Every result transfer is checked against the oldest prediction, field by field. A result
   // reaches rsp only after its byte has passed the input register and the result register, so
   // the prediction is always queued before the checker looks for it.
   always @(posedge clock) begin
      utf8s_pkg::result_type got;
      utf8s_pkg::result_type want;
      string bad;
      if (reset == 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.out_byte     = rsp_bus.out_byte;
         got.was_replaced = rsp_bus.was_replaced;
         got.run_last     = rsp_bus.run_last;
         got.message_last = rsp_bus.message_last;
         if (sanitized_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte %02h", got.out_byte));
         end else begin
            want = sanitized_q.pop_front();
            bad  = "";
            if (got.out_byte !== want.out_byte) bad = {bad, " out_byte"};
            if (got.was_replaced !== want.was_replaced) bad = {bad, " was_replaced"};
            if (got.run_last !== want.run_last) bad = {bad, " run_last"};
            if (got.message_last !== want.message_last) bad = {bad, " message_last"};
            if (bad != "") begin
               report_mismatch($sformatf("wrong%s: got %02h/%b/%b/%b, wanted %02h/%b/%b/%b",
                  bad, got.out_byte, got.was_replaced, got.run_last, got.message_last,
                  want.out_byte, want.was_replaced, want.run_last, want.message_last));
            end
            if (want.was_replaced) begin
               replacements_seen++;
            end
         end
         results_checked++;
      end
   end

   // ---------------------------------------------------------------------------------------------
   // Directed tests.
   // ---------------------------------------------------------------------------------------------

   // Single bytes at the edges of the byte range: the top of ASCII passes, while NUL, a stray
   // continuation byte, an overlong-only lead and a byte that can never appear are replaced.
   task automatic test_single_bytes();
      push_byte(8'h7F, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hBF, 1'b0);
      push_byte(8'hC0, 1'b0);
      push_byte(8'hFF, 1'b1);
   endtask

   // Well-formed characters at the bounds of their ranges, held and then released whole.
   task automatic test_valid_sequences();
      char_bytes = '{8'hDF, 8'hBF};
      send_char(1'b0);
      char_bytes = '{8'hE0, 8'hA0, 8'h80};
      send_char(1'b0);
      char_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
      send_char(1'b1);
   endtask

   // A surrogate, a four-byte overlong and a two-byte lead cut short by ASCII. In each case the
   // lead turns into a question mark and the breaking byte is examined again on its own.
   task automatic test_rejected_sequences();
      push_byte(8'hED, 1'b0);
      push_byte(8'hA0, 1'b0);
      push_byte(8'hF0, 1'b0);
      push_byte(8'h8F, 1'b0);
      push_byte(8'hC2, 1'b0);
      push_byte(8'h41, 1'b0);
   endtask

   // Messages that end in the middle of a character flush every held byte as a question mark.
   task automatic test_truncated_messages();
      push_byte(8'hF0, 1'b0);
      push_byte(8'h90, 1'b0);
      push_byte(8'h80, 1'b1);
      push_byte(8'hC2, 1'b1);
   endtask

   // ---------------------------------------------------------------------------------------------
   // Random text. Most of it is well-formed characters with random content so that every state
   // of the sequence tracker is reached; the rest is ASCII, truncated characters followed by an
   // arbitrary byte or a message end, and plain noise. Idling is on, off, on again, and off for
   // the final stretch.
   // ---------------------------------------------------------------------------------------------
   task automatic test_random_text(input int unsigned count);
      int unsigned first;
      int unsigned done;
      int unsigned kind;
      int unsigned len;
      int unsigned cut;
      logic eom;
      first = bytes_sent;
      while (bytes_sent - first < count) begin
         done = bytes_sent - first;
         stall_send = (done < 150) || (done >= 230 && done < 340);
         stall_recv = (done < 120) || (done >= 200 && done < 340);
         kind = $urandom_range(0, 99);
         eom  = ($urandom_range(0, 5) == 0);
         if (kind < 30) begin
            push_byte(8'($urandom_range(1, 127)), eom);
         end else if (kind < 75) begin
            make_char($urandom_range(2, 4));
            send_char(eom);
         end else if (kind < 88) begin
            len = $urandom_range(2, 4);
            make_char(len);
            cut = $urandom_range(1, len - 1);
            while (char_bytes.size() > cut) begin
               void'(char_bytes.pop_back());
            end
            if (eom) begin
               send_char(1'b1);
            end else begin
               send_char(1'b0);
               push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
         end else begin
            push_byte(8'($urandom_range(0, 255)), eom);
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------------
   // Main sequence: reset once, run the tests in turn, drain, and give the verdict.
   // ---------------------------------------------------------------------------------------------
   initial begin
      int unsigned waited;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.data_byte   <= 8'h00;
      req_bus.message_end <= 1'b0;
      stall_send          = 1'b1;
      stall_recv          = 1'b1;
      recv_gap            = 0;
      mismatches          = 0;
      bytes_sent          = 0;
      messages_sent       = 0;
      results_checked     = 0;
      replacements_seen   = 0;
      pending_count       = '0;
      promised_len        = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_bytes();
      test_valid_sequences();
      test_rejected_sequences();
      test_truncated_messages();
      test_random_text(RandomBytes);

      // All input is in; stop offering bytes and wait for the last results.
      req_bus.valid <= 1'b0;
      stall_send = 1'b0;
      stall_recv = 1'b0;
      waited = 0;
      while (sanitized_q.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      // A few more cycles so that any stray extra result shows up before the verdict.
      repeat (8) @(posedge clock);
      if (sanitized_q.size() != 0) begin
         report_mismatch($sformatf("%0d predicted result bytes never arrived",
            sanitized_q.size()));
      end

      $display("Sent %0d bytes in %0d closed messages; checked %0d result bytes, %0d of them",
         bytes_sent, messages_sent, results_checked, replacements_seen);
      $display("question marks standing in for malformed input.");
      if (mismatches == 0) begin
         $display("utf8_stream_sanitizer_top regression: pass");
      end else begin
         $display("utf8_stream_sanitizer_top regression: fail");
      end
      $finish;
   end

   // Watchdog: a correct run needs well under a millisecond even with heavy idling.
   initial begin
      #6_000_000;
      $display("Timed out waiting for the block.");
      $display("utf8_stream_sanitizer_top regression: fail");
      $finish;
   end

endmodule
